FILE: rtl/slpt_pkg.sv
// package: word types, entry layout and operation/status codes of the parameter lock table
package slpt_pkg;

  localparam logic [2:0] KIND_STORE  = 3'd0;
  localparam logic [2:0] KIND_LOOKUP = 3'd1;
  localparam logic [2:0] KIND_ANY    = 3'd2;
  localparam logic [2:0] KIND_REMOVE = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;
  localparam logic [2:0] KIND_COPY   = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NEW  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] pattern;
    logic [5:0] step;
    logic [7:0] param_id;
    logic [7:0] lock_value;
    logic [3:0] target_pattern;
  } in_word_t;

  typedef struct packed {
    logic       found;
    logic [7:0] read_value;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic [3:0] pattern;
    logic [5:0] step;
    logic [7:0] param_id;
    logic [7:0] value;
  } entry_t;

endpackage

FILE: rtl/step_parameter_lock_table_top.sv
// top level: parameter lock pool with a sequenced scan over one entry memory
//
// usage
// - in_valid/in_ready/in_word carry one operation word (store, lookup,
//   any-for-step, remove step, clear pattern, copy pattern)
// - out_valid/out_ready/out_word return exactly one result word per operation
// - one operation at a time: in_ready is high only while the block is idle
// - every in-range operation walks the whole pool, a memory read state and
//   then a check state for each entry; the result word follows the walk,
//   and a new word is taken only after the result handshake and a return
//   to idle
// - store adds a commit state after its scan
// - copy adds a store scan plus its commit for each source entry it meets
// - out-of-range patterns/steps and unused kinds answer the cycle after accept
// - the entry payload sits in a memory with one read and one write port;
//   valid bits are flops
// - reset clears all valid bits at once, so the pool comes up empty
// - a stalled receiver just holds the result word; nothing is lost
module step_parameter_lock_table_top #(
  parameter int POOL_ENTRIES      = 256,
  parameter int PATTERN_COUNT     = 16,
  parameter int STEPS_PER_PATTERN = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  slpt_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output slpt_pkg::out_word_t out_word
);

  localparam int IDXW = $clog2(POOL_ENTRIES);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_WR, S_OUT} state_t;

  state_t                state_r;
  slpt_pkg::in_word_t    op_r;
  slpt_pkg::entry_t      key_r;      // entry being stored (store or one copy step)
  logic [IDXW-1:0]       idx_r;      // scan pointer
  logic [IDXW-1:0]       src_idx_r;  // copy: source slot to resume after
  logic                  inner_r;    // copy: inside a store scan
  logic                  match_found_r;
  logic [IDXW-1:0]       match_idx_r;
  logic                  free_found_r;
  logic [IDXW-1:0]       free_idx_r;
  logic                  any_new_r;
  logic                  any_full_r;
  logic [POOL_ENTRIES-1:0] valid_r;
  logic                  out_valid_r;
  slpt_pkg::out_word_t   out_word_r;

  // entry payload memory
  slpt_pkg::entry_t      mem [POOL_ENTRIES];
  slpt_pkg::entry_t      ent_r;
  logic                  mem_we;
  logic [IDXW-1:0]       mem_waddr;

  // compares against the word just read
  logic v, hit_pat, hit_step, hit_key, src_hit, last, store_mode, bad;

  assign v          = valid_r[idx_r];
  assign hit_pat    = v && (ent_r.pattern == key_r.pattern);
  assign hit_step   = hit_pat && (ent_r.step == key_r.step);
  assign hit_key    = hit_step && (ent_r.param_id == key_r.param_id);
  assign src_hit    = v && (ent_r.pattern == op_r.pattern);
  assign last       = (idx_r == IDXW'(POOL_ENTRIES - 1));
  assign store_mode = inner_r || (op_r.kind == slpt_pkg::KIND_STORE);

  // range checks on the incoming word
  always_comb begin
    bad = (int'(in_word.pattern) >= PATTERN_COUNT);
    unique case (in_word.kind)
      slpt_pkg::KIND_STORE, slpt_pkg::KIND_LOOKUP,
      slpt_pkg::KIND_ANY, slpt_pkg::KIND_REMOVE:
        bad = bad || (int'(in_word.step) >= STEPS_PER_PATTERN);
      slpt_pkg::KIND_CLEAR: ;
      slpt_pkg::KIND_COPY:
        bad = bad || (int'(in_word.target_pattern) >= PATTERN_COUNT)
                  || (in_word.target_pattern == in_word.pattern);
      default: bad = 1'b1;
    endcase
  end

  assign mem_we    = (state_r == S_WR) && (match_found_r || free_found_r);
  assign mem_waddr = match_found_r ? match_idx_r : free_idx_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= key_r;
    end
    ent_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      inner_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r          <= in_word;
            key_r         <= '{pattern: in_word.pattern, step: in_word.step,
                               param_id: in_word.param_id, value: in_word.lock_value};
            idx_r         <= '0;
            inner_r       <= 1'b0;
            match_found_r <= 1'b0;
            free_found_r  <= 1'b0;
            any_new_r     <= 1'b0;
            any_full_r    <= 1'b0;
            out_word_r    <= '0;
            if (bad) begin
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          if (store_mode) begin
            if (hit_key && !match_found_r) begin
              match_found_r <= 1'b1;
              match_idx_r   <= idx_r;
            end
            if (!v && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= idx_r;
            end
          end else begin
            unique case (op_r.kind)
              slpt_pkg::KIND_LOOKUP: begin
                if (hit_key && !out_word_r.found) begin
                  out_word_r.found      <= 1'b1;
                  out_word_r.read_value <= ent_r.value;
                end
              end
              slpt_pkg::KIND_ANY: begin
                if (hit_step) out_word_r.found <= 1'b1;
              end
              slpt_pkg::KIND_REMOVE: begin
                if (hit_step) begin
                  valid_r[idx_r]   <= 1'b0;
                  out_word_r.found <= 1'b1;
                end
              end
              slpt_pkg::KIND_CLEAR: begin
                if (hit_pat) begin
                  valid_r[idx_r]   <= 1'b0;
                  out_word_r.found <= 1'b1;
                end
              end
              default: ;  // copy outer walk handled below
            endcase
          end
          // pointer and phase control
          if (!store_mode && op_r.kind == slpt_pkg::KIND_COPY && src_hit) begin
            // start a store of this source entry into the target pattern
            key_r         <= '{pattern: op_r.target_pattern, step: ent_r.step,
                               param_id: ent_r.param_id, value: ent_r.value};
            src_idx_r     <= idx_r;
            inner_r       <= 1'b1;
            match_found_r <= 1'b0;
            free_found_r  <= 1'b0;
            idx_r         <= '0;
            state_r       <= S_RD;
          end else if (last) begin
            if (store_mode) begin
              state_r <= S_WR;
            end else begin
              if (op_r.kind == slpt_pkg::KIND_COPY) begin
                out_word_r.status <= any_full_r ? slpt_pkg::ST_FULL :
                                     (any_new_r ? slpt_pkg::ST_NEW : slpt_pkg::ST_OK);
              end
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_WR: begin
          if (!match_found_r && free_found_r) valid_r[free_idx_r] <= 1'b1;
          if (inner_r) begin
            if (!match_found_r && free_found_r) any_new_r <= 1'b1;
            if (!match_found_r && !free_found_r) any_full_r <= 1'b1;
            inner_r <= 1'b0;
            if (src_idx_r == IDXW'(POOL_ENTRIES - 1)) begin
              out_word_r.status <= (!match_found_r && !free_found_r) || any_full_r ?
                                   slpt_pkg::ST_FULL :
                                   ((!match_found_r && free_found_r) || any_new_r ?
                                    slpt_pkg::ST_NEW : slpt_pkg::ST_OK);
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              idx_r   <= src_idx_r + 1'b1;
              state_r <= S_RD;
            end
          end else begin
            out_word_r.status <= match_found_r ? slpt_pkg::ST_OK :
                                 (free_found_r ? slpt_pkg::ST_NEW : slpt_pkg::ST_FULL);
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: rtl/slpt_checker.sv
// checker: port-level properties of the parameter lock table, bound to the top level
module slpt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input slpt_pkg::out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accepting a word");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.status != 2'd3)
    else $error("unknown status code");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.read_value != 8'd0 |-> out_word.found)
    else $error("read value without a hit");

endmodule

bind step_parameter_lock_table_top slpt_checker u_slpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
